// File: rtl/tga2rgb_pkg.sv
// Shared types, codes and color helpers for the TGA to 2-2-2 stream converter.
package tga2rgb_pkg;

  // Defaults for the top-level parameters and the register
  localparam int unsigned PaletteDepthDefault = 256;
  localparam logic [6:0]  TransparentReset    = 7'h40;

  // Parser phases
  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_SKIP    = 3'd1,
    PH_PALETTE = 3'd2,
    PH_PIXELS  = 3'd3,
    PH_DONE    = 3'd4
  } phase_e;

  // Result kinds carried on the output tuser
  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_PIXEL  = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_e;

  // Image type codes from the header
  localparam logic [7:0] TypeColorMapped = 8'd1;
  localparam logic [7:0] TypeTrueColor   = 8'd2;
  localparam logic [7:0] TypeGrayscale   = 8'd3;

  // Header byte offsets
  localparam logic [4:0] HdrIdLength  = 5'd0;
  localparam logic [4:0] HdrImageType = 5'd2;
  localparam logic [4:0] HdrMapLenLo  = 5'd5;
  localparam logic [4:0] HdrMapLenHi  = 5'd6;
  localparam logic [4:0] HdrMapBits   = 5'd7;
  localparam logic [4:0] HdrWidthLo   = 5'd12;
  localparam logic [4:0] HdrWidthHi   = 5'd13;
  localparam logic [4:0] HdrHeightLo  = 5'd14;
  localparam logic [4:0] HdrHeightHi  = 5'd15;
  localparam logic [4:0] HdrPixelBits = 5'd16;
  localparam logic [4:0] HdrLastByte  = 5'd17;

  // Largest supported item size in bytes; anything above saturates to this plus one
  localparam logic [2:0] MaxItemBytes = 3'd4;

  // One result beat before packing
  typedef struct packed {
    kind_e       kind;
    logic [15:0] width;
    logic [15:0] height;
    logic [6:0]  code;
    logic [15:0] column;
    logic [15:0] row;
    logic        last;
  } result_t;

  // Convert a bits-per-item field to bytes, saturating at five
  function automatic logic [2:0] bytes_from_bits(input logic [7:0] bits);
    logic [4:0] bytes;
    bytes = bits[7:3];
    return (bytes > 5'(MaxItemBytes)) ? 3'd5 : bytes[2:0];
  endfunction

  // Quantize one 8-bit channel to 2 bits, i.e. 3*c/255
  function automatic logic [1:0] chan_code(input logic [7:0] c);
    logic [1:0] q;
    if (c == 8'hff)      q = 2'd3;
    else if (c >= 8'd170) q = 2'd2;
    else if (c >= 8'd85)  q = 2'd1;
    else                  q = 2'd0;
    return q;
  endfunction

  // Pack three channels into a 2-2-2 code, low byte in bits 1:0
  function automatic logic [5:0] color_code(input logic [23:0] v);
    return {chan_code(v[23:16]), chan_code(v[15:8]), chan_code(v[7:0])};
  endfunction

endpackage

// File: rtl/tga_to_rgb222_stream_converter.sv
// Top level of the TGA byte stream to 2-2-2 color pixel stream converter.
// Throughput: one input byte per cycle while the output takes its beats; a stall
// on the output holds the input once both result stages are full.
// A byte that completes a header or a pixel is registered in the first result stage
// and then in the output register; the palette memory read port sets the second stage.
// Reset: parser returns to header byte 0, palette valid bits clear, register to 64;
// no clearing pass, start_of_file clears all palette valid bits at once.
module tga_to_rgb222_stream_converter
  import tga2rgb_pkg::*;
#(
  parameter int unsigned PALETTE_DEPTH = PaletteDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write channel: transparent_code in bits 6:0
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [6:0]  cfg_data_i,
  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte[7:0]
  input  logic        s_axis_tuser,   // start_of_file
  // Output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // image_width[15:0], image_height[31:16], pixel_code[38:32], column[54:39],
  // out_row[70:55], zero pad[71]
  output logic [71:0] m_axis_tdata,
  output logic [1:0]  m_axis_tuser,   // kind[1:0]
  output logic        m_axis_tlast    // last_pixel
);

  localparam int unsigned AddrW = $clog2(PALETTE_DEPTH);

  // Parser state
  phase_e      phase_q, phase_d;
  logic [4:0]  hdr_cnt_q, hdr_cnt_d;
  logic [7:0]  id_len_q, id_len_d;
  logic [7:0]  tga_type_q, tga_type_d;
  logic [15:0] pal_len_q, pal_len_d;
  logic [2:0]  pal_bytes_q, pal_bytes_d;
  logic [15:0] width_q, width_d;
  logic [15:0] height_q, height_d;
  logic [2:0]  pix_bytes_q, pix_bytes_d;
  logic [7:0]  skip_q, skip_d;
  logic [2:0]  bic_q, bic_d;
  logic [23:0] acc_q, acc_d;
  logic [15:0] pal_cnt_q, pal_cnt_d;
  logic [15:0] col_q, col_d;
  logic [15:0] row_q, row_d;
  logic [6:0]  transp_q;

  // Palette memory and its valid bits
  logic [5:0]               pal_mem [PALETTE_DEPTH];
  logic [PALETTE_DEPTH-1:0] pal_vld_q;
  logic                     pal_we;
  logic [AddrW-1:0]         pal_waddr;
  logic [5:0]               pal_wdata;
  logic [5:0]               rd_data_q;
  logic                     rd_vld_q;

  // Pipeline registers
  result_t res_d, s1_q, s1_merged, s2_q;
  logic    res_valid, res_pal;
  logic    s1_valid_q, s1_pal_q, s2_valid_q;
  logic    s2_free, s1_adv, in_acc;

  // Combinational helpers
  phase_e      cur_phase, enter_phase, after_skip_phase;
  logic [4:0]  cur_hdr;
  logic [7:0]  in_byte;
  logic [23:0] new_acc;
  logic [2:0]  new_bic;
  logic        bad;
  logic [16:0] col_inc, row_inc;
  logic        row_end, last;
  logic [15:0] pal_cnt_inc;

  assign in_byte       = s_axis_tdata;
  assign s2_free       = !s2_valid_q || m_axis_tready;
  assign s1_adv        = s1_valid_q && s2_free;
  assign s_axis_tready = !s1_valid_q || s1_adv;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // Phase entered after the header and ID field
  always_comb begin
    enter_phase = ((width_q == 16'd0) || (height_q == 16'd0)) ? PH_DONE : PH_PIXELS;
    if ((tga_type_q == TypeColorMapped) && (pal_len_q != 16'd0)) begin
      after_skip_phase = (pal_bytes_q == 3'd0) ? enter_phase : PH_PALETTE;
    end else begin
      after_skip_phase = enter_phase;
    end
  end

  // Gather the byte into the current item
  always_comb begin
    case (bic_q)
      3'd0:    new_acc = acc_q | {16'd0, in_byte};
      3'd1:    new_acc = acc_q | {8'd0, in_byte, 8'd0};
      3'd2:    new_acc = acc_q | {in_byte, 16'd0};
      default: new_acc = acc_q;
    endcase
    new_bic     = bic_q + 3'd1;
    col_inc     = {1'b0, col_q} + 17'd1;
    row_inc     = {1'b0, row_q} + 17'd1;
    row_end     = (col_inc == {1'b0, width_q});
    last        = row_end && (row_inc == {1'b0, height_q});
    pal_cnt_inc = pal_cnt_q + 16'd1;
  end

  // Parse one beat: next state and the result it causes
  always_comb begin
    phase_d     = phase_q;
    hdr_cnt_d   = hdr_cnt_q;
    id_len_d    = id_len_q;
    tga_type_d  = tga_type_q;
    pal_len_d   = pal_len_q;
    pal_bytes_d = pal_bytes_q;
    width_d     = width_q;
    height_d    = height_q;
    pix_bytes_d = pix_bytes_q;
    skip_d      = skip_q;
    bic_d       = bic_q;
    acc_d       = acc_q;
    pal_cnt_d   = pal_cnt_q;
    col_d       = col_q;
    row_d       = row_q;
    res_d       = '0;
    res_valid   = 1'b0;
    res_pal     = 1'b0;
    pal_we      = 1'b0;
    pal_waddr   = pal_cnt_q[AddrW-1:0];
    pal_wdata   = color_code(new_acc);
    bad         = 1'b0;
    cur_phase   = s_axis_tuser ? PH_HEADER : phase_q;
    cur_hdr     = s_axis_tuser ? 5'd0 : hdr_cnt_q;

    if (in_acc) begin
      case (cur_phase)
        PH_HEADER: begin
          hdr_cnt_d = cur_hdr + 5'd1;
          phase_d   = PH_HEADER;
          case (cur_hdr)
            HdrIdLength:  id_len_d    = in_byte;
            HdrImageType: tga_type_d  = in_byte;
            HdrMapLenLo:  pal_len_d   = {8'd0, in_byte};
            HdrMapLenHi:  pal_len_d   = {in_byte, pal_len_q[7:0]};
            HdrMapBits:   pal_bytes_d = bytes_from_bits(in_byte);
            HdrWidthLo:   width_d     = {8'd0, in_byte};
            HdrWidthHi:   width_d     = {in_byte, width_q[7:0]};
            HdrHeightLo:  height_d    = {8'd0, in_byte};
            HdrHeightHi:  height_d    = {in_byte, height_q[7:0]};
            HdrPixelBits: pix_bytes_d = bytes_from_bits(in_byte);
            default: ;
          endcase
          if (cur_hdr == HdrLastByte) begin
            case (tga_type_q)
              TypeColorMapped: begin
                pix_bytes_d = 3'd1;
                bad         = pal_bytes_q > MaxItemBytes;
              end
              TypeTrueColor: begin
                bad = (pix_bytes_q == 3'd0) || (pix_bytes_q > MaxItemBytes);
              end
              TypeGrayscale: begin
                pix_bytes_d = 3'd1;
              end
              default: bad = 1'b1;
            endcase
            res_valid    = 1'b1;
            res_d.width  = width_q;
            res_d.height = height_q;
            // Start every following item from a clean slate
            bic_d     = 3'd0;
            acc_d     = 24'd0;
            pal_cnt_d = 16'd0;
            col_d     = 16'd0;
            row_d     = 16'd0;
            if (bad) begin
              res_d.kind = KIND_ERROR;
              phase_d    = PH_DONE;
            end else begin
              res_d.kind = KIND_HEADER;
              skip_d     = id_len_q;
              phase_d    = (id_len_q != 8'd0) ? PH_SKIP : after_skip_phase;
            end
          end
        end

        PH_SKIP: begin
          skip_d = skip_q - 8'd1;
          if (skip_q == 8'd1) begin
            phase_d = after_skip_phase;
          end
        end

        PH_PALETTE: begin
          bic_d = new_bic;
          acc_d = new_acc;
          if (new_bic >= pal_bytes_q) begin
            pal_we    = ({1'b0, pal_cnt_q} < 17'(PALETTE_DEPTH));
            pal_cnt_d = pal_cnt_inc;
            bic_d     = 3'd0;
            acc_d     = 24'd0;
            if (pal_cnt_inc == pal_len_q) begin
              col_d   = 16'd0;
              row_d   = 16'd0;
              phase_d = enter_phase;
            end
          end
        end

        PH_PIXELS: begin
          bic_d = new_bic;
          acc_d = new_acc;
          if (new_bic >= pix_bytes_q) begin
            bic_d        = 3'd0;
            acc_d        = 24'd0;
            res_valid    = 1'b1;
            res_d.kind   = KIND_PIXEL;
            res_d.width  = width_q;
            res_d.height = height_q;
            res_d.column = col_q;
            res_d.row    = height_q - 16'd1 - row_q;
            res_d.last   = last;
            if (tga_type_q == TypeColorMapped) begin
              if (new_acc[7:0] == 8'd0) begin
                res_d.code = transp_q;
              end else begin
                // Code arrives from the palette read port one stage later
                res_pal = ({1'b0, new_acc[7:0]} < 9'(PALETTE_DEPTH));
              end
            end else begin
              res_d.code = {1'b0, color_code(new_acc)};
            end
            // Advance the raster position
            if (last) begin
              phase_d = PH_DONE;
            end else if (row_end) begin
              col_d = 16'd0;
              row_d = row_inc[15:0];
            end else begin
              col_d = col_inc[15:0];
            end
          end
        end

        default: ;
      endcase
    end
  end

  // Hold parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HEADER;
      hdr_cnt_q   <= '0;
      id_len_q    <= '0;
      tga_type_q  <= '0;
      pal_len_q   <= '0;
      pal_bytes_q <= '0;
      width_q     <= '0;
      height_q    <= '0;
      pix_bytes_q <= '0;
      skip_q      <= '0;
      bic_q       <= '0;
      acc_q       <= '0;
      pal_cnt_q   <= '0;
      col_q       <= '0;
      row_q       <= '0;
    end else begin
      phase_q     <= phase_d;
      hdr_cnt_q   <= hdr_cnt_d;
      id_len_q    <= id_len_d;
      tga_type_q  <= tga_type_d;
      pal_len_q   <= pal_len_d;
      pal_bytes_q <= pal_bytes_d;
      width_q     <= width_d;
      height_q    <= height_d;
      pix_bytes_q <= pix_bytes_d;
      skip_q      <= skip_d;
      bic_q       <= bic_d;
      acc_q       <= acc_d;
      pal_cnt_q   <= pal_cnt_d;
      col_q       <= col_d;
      row_q       <= row_d;
    end
  end

  // Take configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      transp_q <= TransparentReset;
    end else if (cfg_valid_i) begin
      transp_q <= cfg_data_i;
    end
  end

  // Track which palette entries hold data for this file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pal_vld_q <= '0;
    end else if (in_acc) begin
      if (s_axis_tuser) begin
        pal_vld_q <= '0;
      end else if (pal_we) begin
        pal_vld_q[pal_waddr] <= 1'b1;
      end
    end
  end

  // Write palette entries
  always_ff @(posedge clk_i) begin
    if (pal_we) begin
      pal_mem[pal_waddr] <= pal_wdata;
    end
  end

  // Read the palette at the pixel index, held with the first stage
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rd_data_q <= pal_mem[in_byte[AddrW-1:0]];
      rd_vld_q  <= pal_vld_q[in_byte[AddrW-1:0]];
    end
  end

  // First stage: parsed result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= res_valid;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q     <= res_d;
      s1_pal_q <= res_pal;
    end
  end

  // Merge the palette code into the first-stage result
  always_comb begin
    s1_merged = s1_q;
    if (s1_pal_q) begin
      s1_merged.code = rd_vld_q ? {1'b0, rd_data_q} : 7'd0;
    end
  end

  // Second stage: output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s1_adv) begin
      s2_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      s2_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      s2_q <= s1_merged;
    end
  end

  // Pack the output beat
  assign m_axis_tvalid = s2_valid_q;
  assign m_axis_tdata  = {1'b0, s2_q.row, s2_q.column, s2_q.code, s2_q.height, s2_q.width};
  assign m_axis_tuser  = s2_q.kind;
  assign m_axis_tlast  = s2_q.last;

endmodule
